/* rtl/core/best_fit_buffer_cache_macros.svh */
// assertion macros shared by the best-fit buffer cache rtl
// expects clk and arst_n in the scope of each use
`ifndef BEST_FIT_BUFFER_CACHE_MACROS_SVH
`define BEST_FIT_BUFFER_CACHE_MACROS_SVH

// checked only out of reset
`define BFBC_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// checked at every edge, reset included
`define BFBC_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* rtl/core/bfbc_pkg.sv */
// types, constants and codes of the best-fit buffer cache
// no dependencies; used by bfbc_cell, bfbc_chain and best_fit_buffer_cache
`default_nettype none

package bfbc_pkg;

	localparam int TABLE_DEPTH = 16;
	localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
	localparam int LIM_W       = (CNT_W > 5) ? CNT_W : 5;
	localparam int SIZE_W      = 32;
	localparam int HANDLE_W    = 48;
	localparam int CFG_IDX_W   = 2;

	// register indexes of the configuration port
	localparam logic [CFG_IDX_W-1:0] REG_BUFFER_LIMIT = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_BYTE_LIMIT   = 2'd1;

	localparam logic [4:0]        BUF_LIMIT_RESET  = 5'd16;
	localparam logic [SIZE_W-1:0] BYTE_LIMIT_RESET = '1;
	localparam logic [31:0]       SAT_MAX          = '1;

	typedef enum logic [1:0] {
		CMD_GET    = 2'd0,
		CMD_RETURN = 2'd1,
		CMD_CLEAR  = 2'd2,
		CMD_NOP    = 2'd3
	} cmd_t;

	// operation broadcast to every cell of the chain
	typedef enum logic [1:0] {
		OP_HOLD   = 2'd0,
		OP_REMOVE = 2'd1,
		OP_INSERT = 2'd2,
		OP_POP    = 2'd3
	} cell_op_t;

	typedef struct packed {
		logic [1:0]          command;
		logic [SIZE_W-1:0]   request_size;
		logic [HANDLE_W-1:0] handle_in;
	} req_t;

	typedef struct packed {
		logic                hit;
		logic [HANDLE_W-1:0] out_handle;
		logic                released_valid;
		logic                evicted_valid;
		logic [HANDLE_W-1:0] evicted_handle;
		logic                kept;
		logic [4:0]          cached_count;
		logic [31:0]         cached_total;
		logic [31:0]         hit_total;
		logic [31:0]         miss_total;
		logic                last;
	} rsp_t;

	typedef struct packed {
		logic [SIZE_W-1:0]   size;
		logic [HANDLE_W-1:0] handle;
	} entry_t;

	typedef struct packed {
		cell_op_t            op;
		logic                strict;
		logic [SIZE_W-1:0]   key;
		logic [HANDLE_W-1:0] handle_new;
	} cell_ctl_t;

endpackage

`default_nettype wire

/* rtl/core/bfbc_cell.sv */
// one cell of the sorted buffer chain: holds one size and handle
// depends on bfbc_pkg
`default_nettype none

module bfbc_cell (
	input  wire logic               clk,
	input  wire bfbc_pkg::cell_ctl_t ctl,
	input  wire logic               occ,
	input  wire logic               flag_lo,
	input  wire bfbc_pkg::entry_t   lower,
	input  wire bfbc_pkg::entry_t   upper,
	output bfbc_pkg::entry_t        entry,
	output logic                    flag,
	output logic                    first
);

	bfbc_pkg::entry_t entry_q;
	logic             cmp;

	// empty cells always sit past the key, so flags rise once along the chain
	always_comb begin
		if (ctl.strict) begin
			cmp = entry_q.size > ctl.key;
		end else begin
			cmp = entry_q.size >= ctl.key;
		end
		flag  = !occ || cmp;
		first = flag && !flag_lo;
	end

	assign entry = entry_q;

	// shift toward the head on remove or pop, away from it on insert
	always_ff @(posedge clk) begin
		case (ctl.op)
			bfbc_pkg::OP_REMOVE: begin
				if (flag) begin
					entry_q <= upper;
				end
			end
			bfbc_pkg::OP_INSERT: begin
				if (first) begin
					entry_q <= {ctl.key, ctl.handle_new};
				end else if (flag) begin
					entry_q <= lower;
				end
			end
			bfbc_pkg::OP_POP: begin
				entry_q <= upper;
			end
			default: begin
				entry_q <= entry_q;
			end
		endcase
	end

endmodule

`default_nettype wire

/* rtl/core/bfbc_chain.sv */
// row of bfbc_cell linked to their neighbors, plus the pick of the first match
// depends on bfbc_pkg and bfbc_cell
`default_nettype none

module bfbc_chain (
	input  wire logic                       clk,
	input  wire bfbc_pkg::cell_ctl_t        ctl,
	input  wire logic [bfbc_pkg::CNT_W-1:0] count,
	output bfbc_pkg::entry_t                sel,
	output logic                            sel_occ,
	output bfbc_pkg::entry_t                head
);

	bfbc_pkg::entry_t ent   [bfbc_pkg::TABLE_DEPTH];
	bfbc_pkg::entry_t ent_lo[bfbc_pkg::TABLE_DEPTH];
	bfbc_pkg::entry_t ent_hi[bfbc_pkg::TABLE_DEPTH];
	logic [bfbc_pkg::TABLE_DEPTH-1:0] occ;
	logic [bfbc_pkg::TABLE_DEPTH-1:0] flag;
	logic [bfbc_pkg::TABLE_DEPTH-1:0] flag_lo;
	logic [bfbc_pkg::TABLE_DEPTH-1:0] first;

	genvar i;
	generate
		for (i = 0; i < bfbc_pkg::TABLE_DEPTH; i++) begin : g_cell
			// neighbor links, zero past either end
			if (i == 0) begin : g_lo_end
				assign ent_lo[i]  = '0;
				assign flag_lo[i] = 1'b0;
			end else begin : g_lo
				assign ent_lo[i]  = ent[i-1];
				assign flag_lo[i] = flag[i-1];
			end
			if (i == bfbc_pkg::TABLE_DEPTH - 1) begin : g_hi_end
				assign ent_hi[i] = '0;
			end else begin : g_hi
				assign ent_hi[i] = ent[i+1];
			end

			assign occ[i] = count > bfbc_pkg::CNT_W'(i);

			bfbc_cell u_cell (
				.clk     (clk),
				.ctl     (ctl),
				.occ     (occ[i]),
				.flag_lo (flag_lo[i]),
				.lower   (ent_lo[i]),
				.upper   (ent_hi[i]),
				.entry   (ent[i]),
				.flag    (flag[i]),
				.first   (first[i])
			);
		end
	endgenerate

	// one-hot pick of the first flagged cell: at or past the key, or past it when strict
	always_comb begin
		sel     = '0;
		sel_occ = 1'b0;
		for (int k = 0; k < bfbc_pkg::TABLE_DEPTH; k++) begin
			if (first[k]) begin
				sel     = sel | ent[k];
				sel_occ = sel_occ | occ[k];
			end
		end
	end

	assign head = ent[0];

endmodule

`default_nettype wire

/* rtl/core/best_fit_buffer_cache.sv */
// top level of the best-fit buffer cache: sequencer, limits, counters, result register
// depends on bfbc_pkg, bfbc_chain and best_fit_buffer_cache_macros.svh
//
// channel  direction  handshake              payload
// req      in         req_valid/req_ready    bfbc_pkg::req_t
// rsp      out        rsp_valid/rsp_ready    bfbc_pkg::rsp_t
// cfg      in         cfg_valid/cfg_ready    cfg_index, cfg_data
//
// get, plain return, nop and clear of an empty table: accepted in S_IDLE, result loaded from S_EXEC
// return with eviction: S_EXEC pops the smallest entry, S_EXEC2 loads the result
// clear of n entries: S_EXEC, then one item per entry from S_CLEAR, which pops the chain for each item
// the sequencing is paced by the cell chain, which moves at most one step per cycle
// reset clears count, totals and counters and sets the limits to their reset values; no clearing pass over the cells
// a stalled result holds the sequencer; a new item is taken while the last result waits
// cfg_ready is always high
`default_nettype none
`include "best_fit_buffer_cache_macros.svh"

module best_fit_buffer_cache (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               req_valid,
	output logic                                    req_ready,
	input  wire bfbc_pkg::req_t                     req,
	output logic                                    rsp_valid,
	input  wire logic                               rsp_ready,
	output bfbc_pkg::rsp_t                          rsp,
	input  wire logic                               cfg_valid,
	output logic                                    cfg_ready,
	input  wire logic [bfbc_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  wire logic [31:0]                        cfg_data
);

	typedef enum logic [1:0] {
		S_IDLE,
		S_EXEC,
		S_EXEC2,
		S_CLEAR
	} state_t;

	state_t                             state_q, state_d;
	bfbc_pkg::req_t                     req_q, req_d;
	logic [bfbc_pkg::CNT_W-1:0]         count_q, count_d;
	logic [bfbc_pkg::CNT_W-1:0]         clr_left_q, clr_left_d;
	logic [31:0]                        bytes_q, bytes_d;
	logic [31:0]                        hits_q, hits_d;
	logic [31:0]                        misses_q, misses_d;
	logic [bfbc_pkg::HANDLE_W-1:0]      evict_q, evict_d;
	logic [4:0]                         buf_lim_q;
	logic [31:0]                        byte_lim_q;
	bfbc_pkg::rsp_t                     rsp_q, rsp_d;
	logic                               rsp_valid_q;
	logic                               rsp_load;

	bfbc_pkg::cell_ctl_t                ctl;
	bfbc_pkg::entry_t                   sel;
	bfbc_pkg::entry_t                   head;
	logic                               sel_occ;

	logic                               fire;
	logic                               get_hit;
	logic                               room;
	logic                               bytes_fit;
	logic [bfbc_pkg::LIM_W-1:0]         lim;

	bfbc_chain u_chain (
		.clk     (clk),
		.ctl     (ctl),
		.count   (count_q),
		.sel     (sel),
		.sel_occ (sel_occ),
		.head    (head)
	);

	assign req_ready = (state_q == S_IDLE);
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;
	assign cfg_ready = 1'b1;
	assign fire      = !rsp_valid_q || rsp_ready;

	// fit tests against the latched item
	always_comb begin
		lim = (bfbc_pkg::LIM_W'(buf_lim_q) < bfbc_pkg::LIM_W'(bfbc_pkg::TABLE_DEPTH))
			? bfbc_pkg::LIM_W'(buf_lim_q) : bfbc_pkg::LIM_W'(bfbc_pkg::TABLE_DEPTH);
		room      = bfbc_pkg::LIM_W'(count_q) < lim;
		bytes_fit = ({1'b0, bytes_q} + {1'b0, req_q.request_size}) <= {1'b0, byte_lim_q};
		get_hit   = (req_q.request_size != '0) && sel_occ &&
			({1'b0, sel.size} <= {req_q.request_size, 1'b0});
	end

	// sequencer
	always_comb begin
		state_d    = state_q;
		req_d      = req_q;
		count_d    = count_q;
		clr_left_d = clr_left_q;
		bytes_d    = bytes_q;
		hits_d     = hits_q;
		misses_d   = misses_q;
		evict_d    = evict_q;
		rsp_load   = 1'b0;
		rsp_d      = '0;
		rsp_d.last = 1'b1;

		ctl.op         = bfbc_pkg::OP_HOLD;
		ctl.strict     = (req_q.command == bfbc_pkg::CMD_RETURN);
		ctl.key        = req_q.request_size;
		ctl.handle_new = req_q.handle_in;

		case (state_q)
			S_IDLE: begin
				if (req_valid) begin
					req_d   = req;
					state_d = S_EXEC;
				end
			end
			S_EXEC: begin
				if (fire) begin
					state_d  = S_IDLE;
					rsp_load = 1'b1;
					case (req_q.command)
						bfbc_pkg::CMD_GET: begin
							if (get_hit) begin
								ctl.op           = bfbc_pkg::OP_REMOVE;
								count_d          = count_q - bfbc_pkg::CNT_W'(1);
								bytes_d          = bytes_q - sel.size;
								hits_d           = (hits_q != bfbc_pkg::SAT_MAX)
									? hits_q + 32'd1 : hits_q;
								rsp_d.hit        = 1'b1;
								rsp_d.out_handle = sel.handle;
							end else begin
								misses_d = (misses_q != bfbc_pkg::SAT_MAX)
									? misses_q + 32'd1 : misses_q;
							end
						end
						bfbc_pkg::CMD_RETURN: begin
							if (req_q.handle_in != '0 && req_q.request_size != '0) begin
								if (room && bytes_fit) begin
									ctl.op     = bfbc_pkg::OP_INSERT;
									count_d    = count_q + bfbc_pkg::CNT_W'(1);
									bytes_d    = bytes_q + req_q.request_size;
									rsp_d.kept = 1'b1;
								end else if (count_q != '0 && req_q.request_size > head.size) begin
									// evict the smallest, then retry the byte limit
									ctl.op   = bfbc_pkg::OP_POP;
									count_d  = count_q - bfbc_pkg::CNT_W'(1);
									bytes_d  = bytes_q - head.size;
									evict_d  = head.handle;
									rsp_load = 1'b0;
									state_d  = S_EXEC2;
								end
							end
						end
						bfbc_pkg::CMD_CLEAR: begin
							if (count_q != '0) begin
								clr_left_d = count_q;
								count_d    = '0;
								bytes_d    = '0;
								rsp_load   = 1'b0;
								state_d    = S_CLEAR;
							end
						end
						default: begin
						end
					endcase
				end
			end
			S_EXEC2: begin
				if (fire) begin
					state_d              = S_IDLE;
					rsp_load             = 1'b1;
					rsp_d.evicted_valid  = 1'b1;
					rsp_d.evicted_handle = evict_q;
					if (bytes_fit) begin
						ctl.op     = bfbc_pkg::OP_INSERT;
						count_d    = count_q + bfbc_pkg::CNT_W'(1);
						bytes_d    = bytes_q + req_q.request_size;
						rsp_d.kept = 1'b1;
					end
				end
			end
			S_CLEAR: begin
				// release the head each cycle that the result can be taken and pop the chain
				if (fire) begin
					rsp_load             = 1'b1;
					ctl.op               = bfbc_pkg::OP_POP;
					rsp_d.out_handle     = head.handle;
					rsp_d.released_valid = 1'b1;
					rsp_d.last           = (clr_left_q == bfbc_pkg::CNT_W'(1));
					clr_left_d           = clr_left_q - bfbc_pkg::CNT_W'(1);
					if (clr_left_q == bfbc_pkg::CNT_W'(1)) begin
						state_d = S_IDLE;
					end
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase

		// table and counter status after the step
		rsp_d.cached_count = 5'(count_d);
		rsp_d.cached_total = bytes_d;
		rsp_d.hit_total    = hits_d;
		rsp_d.miss_total   = misses_d;
	end

	// state, limits and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			req_q       <= '0;
			count_q     <= '0;
			clr_left_q  <= '0;
			bytes_q     <= '0;
			hits_q      <= '0;
			misses_q    <= '0;
			evict_q     <= '0;
			buf_lim_q   <= bfbc_pkg::BUF_LIMIT_RESET;
			byte_lim_q  <= bfbc_pkg::BYTE_LIMIT_RESET;
			rsp_q       <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q    <= state_d;
			req_q      <= req_d;
			count_q    <= count_d;
			clr_left_q <= clr_left_d;
			bytes_q    <= bytes_d;
			hits_q     <= hits_d;
			misses_q   <= misses_d;
			evict_q    <= evict_d;
			if (rsp_load) begin
				rsp_q       <= rsp_d;
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
			if (cfg_valid) begin
				case (cfg_index)
					bfbc_pkg::REG_BUFFER_LIMIT: begin
						buf_lim_q <= cfg_data[4:0];
					end
					bfbc_pkg::REG_BYTE_LIMIT: begin
						byte_lim_q <= cfg_data;
					end
					default: begin
					end
				endcase
			end
		end
	end

	// checks
	`BFBC_ASSERT(a_count_bound,
		count_q <= bfbc_pkg::CNT_W'(bfbc_pkg::TABLE_DEPTH),
		"table count above depth")
	`BFBC_ASSERT(a_empty_no_bytes,
		(count_q == '0) |-> (bytes_q == '0),
		"bytes cached with empty table")
	`BFBC_ASSERT(a_hit_removes,
		(state_q == S_EXEC && fire && req_q.command == bfbc_pkg::CMD_GET && get_hit)
		|=> (count_q == $past(count_q) - bfbc_pkg::CNT_W'(1)),
		"hit did not remove one entry")
	`BFBC_ASSERT(a_clear_left,
		(state_q == S_CLEAR) |-> (clr_left_q != '0),
		"clear run with nothing left")

endmodule

`default_nettype wire
